[hdl/sla_pkg.sv]
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types, opcode codes and compare helpers for the long ALU/branch unit.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned DIV_STEPS = XLEN;
  localparam logic [31:0] PC_STEP   = 32'd4;

  // Opcode codes
  localparam logic [5:0] OP_NOP  = 6'd0;
  localparam logic [5:0] OP_NEG  = 6'd1;
  localparam logic [5:0] OP_ABS  = 6'd2;
  localparam logic [5:0] OP_INC  = 6'd3;
  localparam logic [5:0] OP_DEC  = 6'd4;
  localparam logic [5:0] OP_NOT  = 6'd5;
  localparam logic [5:0] OP_ADD  = 6'd6;
  localparam logic [5:0] OP_SUB  = 6'd7;
  localparam logic [5:0] OP_MUL  = 6'd8;
  localparam logic [5:0] OP_UMUL = 6'd9;
  localparam logic [5:0] OP_DIV  = 6'd10;
  localparam logic [5:0] OP_UDIV = 6'd11;
  localparam logic [5:0] OP_MOD  = 6'd12;
  localparam logic [5:0] OP_UMOD = 6'd13;
  localparam logic [5:0] OP_SLL  = 6'd14;
  localparam logic [5:0] OP_SRL  = 6'd15;
  localparam logic [5:0] OP_SRA  = 6'd16;
  localparam logic [5:0] OP_OR   = 6'd17;
  localparam logic [5:0] OP_AND  = 6'd18;
  localparam logic [5:0] OP_XOR  = 6'd19;
  localparam logic [5:0] OP_ZT0  = 6'd20;
  localparam logic [5:0] OP_PT0  = 6'd26;
  localparam logic [5:0] OP_DUP  = 6'd36;
  localparam logic [5:0] OP_XCHG = 6'd37;
  localparam logic [5:0] OP_ZB0  = 6'd38;
  localparam logic [5:0] OP_PB0  = 6'd44;
  localparam logic [5:0] OP_PB_LAST = 6'd53;

  // Error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_ILL   = 2'd1;
  localparam logic [1:0] ERR_DIV0  = 2'd2;

  // Register indexes
  localparam logic CFG_TRUE  = 1'b0;
  localparam logic CFG_FALSE = 1'b1;

  typedef enum logic [3:0] {
    CLS_NOP, CLS_UNARY, CLS_BINARY, CLS_DIVIDE, CLS_ZTEST, CLS_PTEST,
    CLS_DUP, CLS_XCHG, CLS_ZBRANCH, CLS_PBRANCH, CLS_ILLEGAL
  } cls_t;

  // Classified item handed from front to back
  typedef struct packed {
    cls_t        cls;
    logic [5:0]  opcode;
    logic [31:0] top;
    logic [31:0] nxt;
    logic [15:0] label;
    logic [31:0] pc;
  } item_t;

  // Item in flight through the execution pipe
  typedef struct packed {
    logic [2:0]  pop;
    logic [2:0]  push;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] npc;
    logic [1:0]  err;
    logic        is_div;
    logic        want_rem;
    logic        neg_res;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dsr;
  } exec_t;

  function automatic logic lt_signed(input logic [31:0] a, input logic [31:0] b);
    lt_signed = $signed(a) < $signed(b);
  endfunction

  function automatic logic zero_test(input logic [2:0] sel, input logic [31:0] v);
    logic z;
    z = (v == 32'd0);
    case (sel)
      3'd0:    zero_test = z;
      3'd1:    zero_test = !z;
      3'd2:    zero_test = v[31];
      3'd3:    zero_test = !v[31];
      3'd4:    zero_test = !v[31] && !z;
      default: zero_test = v[31] || z;
    endcase
  endfunction

  function automatic logic pair_test(input logic [3:0] sel, input logic [31:0] a,
                                     input logic [31:0] b);
    case (sel)
      4'd0:    pair_test = (a == b);
      4'd1:    pair_test = (a != b);
      4'd2:    pair_test = lt_signed(a, b);
      4'd3:    pair_test = !lt_signed(a, b);
      4'd4:    pair_test = lt_signed(b, a);
      4'd5:    pair_test = !lt_signed(b, a);
      4'd6:    pair_test = (a < b);
      4'd7:    pair_test = (a >= b);
      4'd8:    pair_test = (a > b);
      default: pair_test = (a <= b);
    endcase
  endfunction

endpackage

[hdl/sla_front.sv]
// ----------------------------------------------------------------------------
// sla_front
// Accepts a command, classifies its opcode and holds it for the queue.
// ----------------------------------------------------------------------------
module sla_front import sla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [5:0]  opcode,
  input  logic [31:0] top_value,
  input  logic [31:0] next_value,
  input  logic [15:0] branch_label,
  input  logic [31:0] current_pc,
  input  logic        q_full,
  output logic        busy,
  output logic        f_valid,
  output item_t       f_item
);

  cls_t cls;

  // Classify the opcode
  always_comb begin
    if (opcode == OP_NOP)                            cls = CLS_NOP;
    else if (opcode <= OP_NOT)                       cls = CLS_UNARY;
    else if (opcode >= OP_DIV && opcode <= OP_UMOD)  cls = CLS_DIVIDE;
    else if (opcode < OP_ZT0)                        cls = CLS_BINARY;
    else if (opcode < OP_PT0)                        cls = CLS_ZTEST;
    else if (opcode < OP_DUP)                        cls = CLS_PTEST;
    else if (opcode == OP_DUP)                       cls = CLS_DUP;
    else if (opcode == OP_XCHG)                      cls = CLS_XCHG;
    else if (opcode < OP_PB0)                        cls = CLS_ZBRANCH;
    else if (opcode <= OP_PB_LAST)                   cls = CLS_PBRANCH;
    else                                             cls = CLS_ILLEGAL;
  end

  // Hold the word while the queue is full
  assign busy = f_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!busy) begin
      f_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      f_item <= '{cls: cls, opcode: opcode, top: top_value, nxt: next_value,
                  label: branch_label, pc: current_pc};
    end
  end

endmodule

[hdl/sla_queue.sv]
// ----------------------------------------------------------------------------
// sla_queue
// Two-entry queue between the front and the execution pipe.
// ----------------------------------------------------------------------------
module sla_queue import sla_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t      slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[hdl/sla_back.sv]
// ----------------------------------------------------------------------------
// sla_back
// Execution pipe: issue stage, one-bit-per-stage divider, result register.
// ----------------------------------------------------------------------------
module sla_back import sla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  item_t       in_item,
  input  logic [15:0] true_word,
  input  logic [15:0] false_word,
  output logic        done,
  output logic [2:0]  pop_words,
  output logic [2:0]  push_words,
  output logic [31:0] push_lower,
  output logic [31:0] push_upper,
  output logic [31:0] next_pc,
  output logic [1:0]  error_code
);

  exec_t       iss;
  exec_t       st   [0:DIV_STEPS];
  logic        st_v [0:DIV_STEPS];
  logic [31:0] t, n, r, pc4;
  logic        cond, na, nb;
  logic [31:0] bool_w;

  assign t   = in_item.top;
  assign n   = in_item.nxt;
  assign pc4 = in_item.pc + PC_STEP;
  assign na  = n[31];
  assign nb  = t[31];

  // Evaluate simple results and divider setup
  always_comb begin
    r    = '0;
    cond = 1'b0;
    case (in_item.opcode)
      OP_NEG:  r = 32'd0 - t;
      OP_ABS:  r = t[31] ? 32'd0 - t : t;
      OP_INC:  r = t + 32'd1;
      OP_DEC:  r = t - 32'd1;
      OP_NOT:  r = ~t;
      OP_ADD:  r = n + t;
      OP_SUB:  r = n - t;
      OP_MUL, OP_UMUL: r = n * t;
      OP_SLL:  r = (t >= 32'd32) ? 32'd0 : (n << t[4:0]);
      OP_SRL:  r = (t >= 32'd32) ? 32'd0 : (n >> t[4:0]);
      OP_SRA:  r = (t >= 32'd32) ? {32{n[31]}} : 32'($signed(n) >>> t[4:0]);
      OP_OR:   r = n | t;
      OP_AND:  r = n & t;
      OP_XOR:  r = n ^ t;
      default: r = '0;
    endcase
    case (in_item.cls)
      CLS_ZTEST:   cond = zero_test(3'(in_item.opcode - OP_ZT0), t);
      CLS_PTEST:   cond = pair_test(4'(in_item.opcode - OP_PT0), t, n);
      CLS_ZBRANCH: cond = zero_test(3'(in_item.opcode - OP_ZB0), t);
      CLS_PBRANCH: cond = pair_test(4'(in_item.opcode - OP_PB0), n, t);
      default:     cond = 1'b0;
    endcase
    bool_w = {16'd0, cond ? true_word : false_word};

    iss = '0;
    iss.npc = pc4;
    case (in_item.cls)
      CLS_UNARY: begin
        iss.pop = 3'd2; iss.push = 3'd2; iss.lo = r;
      end
      CLS_BINARY: begin
        iss.pop = 3'd4; iss.push = 3'd2; iss.lo = r;
      end
      CLS_DIVIDE: begin
        if (t == 32'd0) begin
          iss.err = ERR_DIV0;
        end else begin
          iss.pop    = 3'd4;
          iss.push   = 3'd2;
          iss.is_div = 1'b1;
          iss.want_rem = (in_item.opcode == OP_MOD) || (in_item.opcode == OP_UMOD);
          if (in_item.opcode == OP_DIV || in_item.opcode == OP_MOD) begin
            iss.quo     = na ? 32'd0 - n : n;
            iss.dsr     = nb ? 32'd0 - t : t;
            iss.neg_res = (in_item.opcode == OP_MOD) ? na : (na != nb);
          end else begin
            iss.quo = n;
            iss.dsr = t;
          end
        end
      end
      CLS_ZTEST: begin
        iss.pop = 3'd2; iss.push = 3'd1; iss.lo = bool_w;
      end
      CLS_PTEST: begin
        iss.pop = 3'd4; iss.push = 3'd1; iss.lo = bool_w;
      end
      CLS_DUP: begin
        iss.push = 3'd2; iss.lo = t;
      end
      CLS_XCHG: begin
        iss.pop = 3'd4; iss.push = 3'd4; iss.lo = t; iss.hi = n;
      end
      CLS_ZBRANCH: begin
        iss.pop = 3'd2;
        if (cond) iss.npc = {16'd0, in_item.label};
      end
      CLS_PBRANCH: begin
        iss.pop = 3'd4;
        if (cond) iss.npc = {16'd0, in_item.label};
      end
      CLS_ILLEGAL: iss.err = ERR_ILL;
      default: ;
    endcase
  end

  // Register the issue stage
  always_ff @(posedge clk) begin
    if (rst) st_v[0] <= 1'b0;
    else     st_v[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    st[0] <= iss;
  end

  // Divider: one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] rs;
    logic        ge;
    exec_t       nx;
    always_comb begin
      nx  = st[k];
      rs  = {st[k].rem, st[k].quo[31]};
      ge  = rs >= {1'b0, st[k].dsr};
      nx.rem = ge ? 32'(rs - {1'b0, st[k].dsr}) : rs[31:0];
      nx.quo = {st[k].quo[30:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) st_v[k+1] <= 1'b0;
      else     st_v[k+1] <= st_v[k];
    end
    always_ff @(posedge clk) begin
      st[k+1] <= nx;
    end
  end

  // Select the final value and drive the result ports
  exec_t       fin;
  logic [31:0] mag;
  assign fin = st[DIV_STEPS];
  assign mag = fin.want_rem ? fin.rem : fin.quo;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= st_v[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    pop_words  <= fin.pop;
    push_words <= fin.push;
    push_lower <= fin.is_div ? (fin.neg_res ? 32'd0 - mag : mag) : fin.lo;
    push_upper <= fin.hi;
    next_pc    <= fin.npc;
    error_code <= fin.err;
  end

endmodule

[hdl/stack_long_alu_and_branch.sv]
// ----------------------------------------------------------------------------
// stack_long_alu_and_branch
// One 32-bit operation of a 16-bit-word stack machine, with branches.
//
//   channel   handshake              payload
//   command   start / busy           opcode top_value next_value branch_label
//                                    current_pc
//   result    done (one cycle)       pop_words push_words push_lower
//                                    push_upper next_pc error_code
//   config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// One command per cycle while busy is low. Each command passes through the
// front register, queue, issue stage, 32 divider stages and result register.
// The divider stages set the latency; every command flows through them.
// rst is synchronous; it empties the pipe and reloads the compare words.
// Results cannot be held off; busy only rises if the queue backs up.
// ----------------------------------------------------------------------------
module stack_long_alu_and_branch import sla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  opcode,
  input  logic [31:0] top_value,
  input  logic [31:0] next_value,
  input  logic [15:0] branch_label,
  input  logic [31:0] current_pc,
  output logic        done,
  output logic [2:0]  pop_words,
  output logic [2:0]  push_words,
  output logic [31:0] push_lower,
  output logic [31:0] push_upper,
  output logic [31:0] next_pc,
  output logic [1:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] true_word;
  logic [15:0] false_word;
  logic        f_valid;
  item_t       f_item;
  logic        q_full;
  logic        q_valid;
  item_t       q_item;

  assign cfg_ready = 1'b1;

  // Hold the compare words
  always_ff @(posedge clk) begin
    if (rst) begin
      true_word  <= 16'hFFFF;
      false_word <= 16'h0000;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TRUE) true_word  <= cfg_data;
      else                       false_word <= cfg_data;
    end
  end

  sla_front u_front (
    .clk, .rst, .start, .opcode, .top_value, .next_value, .branch_label,
    .current_pc, .q_full, .busy, .f_valid, .f_item
  );

  sla_queue u_queue (
    .clk, .rst, .push(f_valid), .push_item(f_item), .full(q_full),
    .pop_valid(q_valid), .pop_item(q_item)
  );

  sla_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_item(q_item), .true_word, .false_word,
    .done, .pop_words, .push_words, .push_lower, .push_upper, .next_pc,
    .error_code
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for stack_long_alu_and_branch
// Drives opcode words through the start/busy command port, predicts each
// result from a behavioral model of the unit and checks every done word in
// order. The compare words are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import sla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  op;
    logic [31:0] top;
    logic [31:0] nxt;
    logic [15:0] label;
    logic [31:0] pc;
  } cmd_t;

  typedef struct {
    logic [2:0]  pop;
    logic [2:0]  push;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] npc;
    logic [1:0]  err;
  } outcome_t;

  localparam int LATENCY = 36;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  opcode = '0;
  logic [31:0] top_value = '0;
  logic [31:0] next_value = '0;
  logic [15:0] branch_label = '0;
  logic [31:0] current_pc = '0;
  logic        done;
  logic [2:0]  pop_words;
  logic [2:0]  push_words;
  logic [31:0] push_lower;
  logic [31:0] push_upper;
  logic [31:0] next_pc;
  logic [1:0]  error_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  cmd_t     pending_cmds[$];
  outcome_t expected_outcomes[$];
  logic [15:0] true_word_m;
  logic [15:0] false_word_m;
  int       errors = 0;
  int       gap_left = 0;
  bit       cfg_pending = 1'b0;
  logic     start_hold = 1'b0;

  stack_long_alu_and_branch uut (.*);

  always #5 clk = ~clk;

  // Signed and unsigned divide with truncation toward zero
  function automatic logic [31:0] div_result(logic [31:0] a, logic [31:0] b,
                                             bit sgn, bit rem);
    logic [31:0] ma, mb, q, r;
    ma = (sgn && a[31]) ? -a : a;
    mb = (sgn && b[31]) ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (!sgn) return rem ? r : q;
    if (rem) return a[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic bit zero_cond(int sel, logic [31:0] v);
    case (sel)
      0: return v == 0;
      1: return v != 0;
      2: return v[31];
      3: return !v[31];
      4: return !v[31] && v != 0;
      default: return v[31] || v == 0;
    endcase
  endfunction

  function automatic bit pair_cond(int sel, logic [31:0] a, logic [31:0] b);
    case (sel)
      0: return a == b;
      1: return a != b;
      2: return $signed(a) < $signed(b);
      3: return $signed(a) >= $signed(b);
      4: return $signed(a) > $signed(b);
      5: return $signed(a) <= $signed(b);
      6: return a < b;
      7: return a >= b;
      8: return a > b;
      default: return a <= b;
    endcase
  endfunction

  function automatic outcome_t predict_outcome(cmd_t c);
    outcome_t o;
    logic [31:0] t, n;
    t = c.top;
    n = c.nxt;
    o = '{pop: 3'd0, push: 3'd0, lo: 32'd0, hi: 32'd0, npc: c.pc + PC_STEP,
          err: ERR_OK};
    if (c.op >= OP_NEG && c.op <= OP_NOT) begin
      o.pop = 3'd2; o.push = 3'd2;
      case (c.op)
        OP_NEG: o.lo = -t;
        OP_ABS: o.lo = t[31] ? -t : t;
        OP_INC: o.lo = t + 32'd1;
        OP_DEC: o.lo = t - 32'd1;
        default: o.lo = ~t;
      endcase
    end else if (c.op >= OP_ADD && c.op <= OP_XOR) begin
      if (c.op >= OP_DIV && c.op <= OP_UMOD && t == 0) begin
        o.err = ERR_DIV0;
      end else begin
        o.pop = 3'd4; o.push = 3'd2;
        case (c.op)
          OP_ADD: o.lo = n + t;
          OP_SUB: o.lo = n - t;
          OP_MUL, OP_UMUL: o.lo = n * t;
          OP_DIV: o.lo = div_result(n, t, 1, 0);
          OP_UDIV: o.lo = div_result(n, t, 0, 0);
          OP_MOD: o.lo = div_result(n, t, 1, 1);
          OP_UMOD: o.lo = div_result(n, t, 0, 1);
          OP_SLL: o.lo = (t >= 32) ? 32'd0 : n << t[4:0];
          OP_SRL: o.lo = (t >= 32) ? 32'd0 : n >> t[4:0];
          OP_SRA: o.lo = (t >= 32) ? {32{n[31]}} : 32'($signed(n) >>> t[4:0]);
          OP_OR: o.lo = n | t;
          OP_AND: o.lo = n & t;
          default: o.lo = n ^ t;
        endcase
      end
    end else if (c.op >= OP_ZT0 && c.op < OP_PT0) begin
      o.pop = 3'd2; o.push = 3'd1;
      o.lo = {16'd0, zero_cond(c.op - OP_ZT0, t) ? true_word_m : false_word_m};
    end else if (c.op >= OP_PT0 && c.op < OP_DUP) begin
      o.pop = 3'd4; o.push = 3'd1;
      o.lo = {16'd0, pair_cond(c.op - OP_PT0, t, n) ? true_word_m : false_word_m};
    end else if (c.op == OP_DUP) begin
      o.push = 3'd2; o.lo = t;
    end else if (c.op == OP_XCHG) begin
      o.pop = 3'd4; o.push = 3'd4; o.lo = t; o.hi = n;
    end else if (c.op >= OP_ZB0 && c.op < OP_PB0) begin
      o.pop = 3'd2;
      if (zero_cond(c.op - OP_ZB0, t)) o.npc = {16'd0, c.label};
    end else if (c.op >= OP_PB0 && c.op <= OP_PB_LAST) begin
      o.pop = 3'd4;
      if (pair_cond(c.op - OP_PB0, n, t)) o.npc = {16'd0, c.label};
    end else if (c.op != OP_NOP) begin
      o.err = ERR_ILL;
    end
    return o;
  endfunction

  // Operand with bias toward edge values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(54, 63))
                                        : 6'($urandom_range(0, 53));
    c.top = rand_word();
    c.nxt = ($urandom_range(0, 4) == 0) ? c.top : rand_word();
    c.label = 16'($urandom);
    c.pc = $urandom;
    return c;
  endfunction

  // Driver: present one word per start, with random gaps
  always @(negedge clk) begin
    if (!rst && !cfg_pending) begin
      if (!start_hold) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          opcode <= c.op;
          top_value <= c.top;
          next_value <= c.nxt;
          branch_label <= c.label;
          current_pc <= c.pc;
          start <= 1'b1;
          start_hold <= 1'b1;
          expected_outcomes.push_back(predict_outcome(c));
        end
      end
    end
  end

  // Acceptance at the rising edge; lower start and draw the gap before the next word
  always @(posedge clk) begin
    if (start && !busy) begin
      start_hold <= 1'b0;
      start <= 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2: gap_left <= $urandom_range(1, 3);
        3: gap_left <= $urandom_range(10, 40);
        default: gap_left <= 0;
      endcase
    end
  end

  // Monitor: check every done word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result next_pc=%h", $time, next_pc);
        errors++;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (pop_words !== e.pop) begin
          $display("%0t: pop_words exp %0d got %0d", $time, e.pop, pop_words); errors++;
        end
        if (push_words !== e.push) begin
          $display("%0t: push_words exp %0d got %0d", $time, e.push, push_words); errors++;
        end
        if (push_lower !== e.lo) begin
          $display("%0t: push_lower exp %h got %h", $time, e.lo, push_lower); errors++;
        end
        if (push_upper !== e.hi) begin
          $display("%0t: push_upper exp %h got %h", $time, e.hi, push_upper); errors++;
        end
        if (next_pc !== e.npc) begin
          $display("%0t: next_pc exp %h got %h", $time, e.npc, next_pc); errors++;
        end
        if (error_code !== e.err) begin
          $display("%0t: error_code exp %0d got %0d", $time, e.err, error_code); errors++;
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TRUE) true_word_m = value;
    else false_word_m = value;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic run_phase(int count);
    cfg_pending = 1'b0;
    repeat (count) pending_cmds.push_back(rand_cmd());
    drain();
    cfg_pending = 1'b1;
  endtask

  initial begin
    cmd_t c;
    logic [31:0] edge_vals[6];
    true_word_m = 16'hFFFF;
    false_word_m = 16'h0000;
    cfg_pending = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: every third opcode code from 0 to 63 at extreme operands, then special cases
    edge_vals = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'd1, 32'd32};
    for (int i = 0; i < 24; i++) begin
      c.op = (i < 22) ? 6'(i * 3 % 64) : 6'd63;
      c.top = edge_vals[i % 6];
      c.nxt = edge_vals[(i + 2) % 6];
      c.label = (i % 2) ? 16'hFFFF : 16'h0;
      c.pc = (i % 2) ? 32'hFFFF_FFFC : 32'h0;
      pending_cmds.push_back(c);
    end
    pending_cmds.push_back(cmd_t'{OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000, 16'h1234, 32'd8});
    pending_cmds.push_back(cmd_t'{OP_MOD, 32'hFFFF_FFFF, 32'h8000_0000, 16'h1234, 32'd8});
    pending_cmds.push_back(cmd_t'{OP_UMOD, 32'h0, 32'd5, 16'h1234, 32'd8});
    pending_cmds.push_back(cmd_t'{OP_SRA, 32'hFFFF_FFE0, 32'h8000_0001, 16'h0, 32'd8});
    pending_cmds.push_back(cmd_t'{OP_ABS, 32'h8000_0000, 32'h0, 16'h0, 32'd8});
    cfg_pending = 1'b0;
    drain();
    cfg_pending = 1'b1;
    // random phases across compare-word settings
    run_phase(300);
    write_reg(CFG_TRUE, 16'h0000);
    write_reg(CFG_FALSE, 16'hFFFF);
    run_phase(400);
    write_reg(CFG_TRUE, 16'h0001);
    write_reg(CFG_FALSE, 16'h0001);
    run_phase(400);
    write_reg(CFG_TRUE, 16'($urandom));
    write_reg(CFG_FALSE, 16'($urandom));
    run_phase(420);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/sla_pkg.sv
hdl/sla_front.sv
hdl/sla_queue.sv
hdl/sla_back.sv
hdl/stack_long_alu_and_branch.sv
tb/tb.sv
